>>> rtl/core/sclfu_pkg.sv
`timescale 1ns / 1ps

package sclfu_pkg;

  localparam int unsigned NUM_BUCKETS_DEF = 2039;
  localparam int unsigned WAYS_DEF        = 8;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned TAG_W  = 64;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned NUM_W  = 32;
  localparam int unsigned IDX_W  = 14;

  // multiply, subtract, correct
  localparam int unsigned MOD_CYCLES = 3;
  localparam int unsigned MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] cnt;
    logic [NUM_W-1:0] num;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic load_in;
    logic mod_step;
    logic rd_valid;
    logic scan_eval;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/sclfu_ctrl.sv
`timescale 1ns / 1ps

module sclfu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sclfu_pkg::status_t status_i,
  output sclfu_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MOD   = 6'b000100,
    ST_VRD   = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) begin
          state_d = ST_VRD;
        end
      end
      ST_VRD: begin
        cmd_o.rd_valid = 1'b1;
        state_d        = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_eval = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

>>> rtl/core/sclfu_datapath.sv
`timescale 1ns / 1ps

module sclfu_datapath #(
  parameter int unsigned NUM_BUCKETS = sclfu_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned WAYS        = sclfu_pkg::WAYS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sclfu_pkg::cmd_t              cmd_i,
  output sclfu_pkg::status_t           status_o,
  input  logic [sclfu_pkg::HASH_W-1:0] query_hash_i,
  input  logic [sclfu_pkg::TAG_W-1:0]  query_tag_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [sclfu_pkg::IDX_W-1:0]  entry_index_o,
  output logic [sclfu_pkg::NUM_W-1:0]  stmt_number_o,
  output logic                         evicted_o,
  output logic [sclfu_pkg::NUM_W-1:0]  evicted_number_o
);

  localparam int unsigned BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned DEPTH  = NUM_BUCKETS * WAYS;
  localparam int unsigned ENT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned PROD_W = 2 * sclfu_pkg::HASH_W;
  localparam int unsigned RCP_SH = 31 + $clog2(NUM_BUCKETS);
  localparam logic [sclfu_pkg::HASH_W-1:0] RCP_M =
    sclfu_pkg::HASH_W'((64'd1 << RCP_SH) / 64'(NUM_BUCKETS));

  logic [WAYS-1:0]          vmem [NUM_BUCKETS];
  sclfu_pkg::entry_t        emem [DEPTH];

  logic [BKT_W-1:0]                clr_q;
  logic [sclfu_pkg::MOD_CNT_W-1:0] mod_cnt_q;
  logic [sclfu_pkg::HASH_W-1:0]    hash_q;
  logic [sclfu_pkg::TAG_W-1:0]     tag_q;
  logic [PROD_W-1:0]               prod_q;
  logic [BKT_W:0]                  est_q;
  logic [BKT_W-1:0]                rem_q;
  logic [WAY_W-1:0]                way_q;
  logic [WAYS-1:0]                 vrow_q;
  sclfu_pkg::entry_t               rd_q;
  logic [sclfu_pkg::NUM_W-1:0]     next_num_q;

  logic                        found_q, free_q;
  logic [WAY_W-1:0]            hit_way_q, pick_q;
  logic [sclfu_pkg::CNT_W-1:0] hit_cnt_q, min_q;
  logic [sclfu_pkg::NUM_W-1:0] hit_num_q, pick_num_q;

  logic                        out_valid_q;
  logic                        hit_q, evicted_q;
  logic [sclfu_pkg::IDX_W-1:0] idx_q;
  logic [sclfu_pkg::NUM_W-1:0] stmt_q, ev_num_q;

  logic [sclfu_pkg::HASH_W-1:0] quot, rem_raw;
  logic [BKT_W-1:0]             rem_fix;
  logic [ENT_W-1:0]            base;
  logic [WAY_W-1:0]            rd_way, sel_way;
  logic                        rd_en, cur_valid;
  logic [31:0]                 idx_full;
  sclfu_pkg::entry_t           wr_word;
  logic [WAYS-1:0]             pick_mask;
  logic [sclfu_pkg::CNT_W-1:0] cnt_inc;
  logic [sclfu_pkg::NUM_W-1:0] num_inc;

  // bucket by reciprocal multiply: estimate, subtract, one correction
  assign quot    = sclfu_pkg::HASH_W'(prod_q >> RCP_SH);
  assign rem_raw = hash_q - quot * sclfu_pkg::HASH_W'(NUM_BUCKETS);
  assign rem_fix = (est_q >= (BKT_W+1)'(NUM_BUCKETS)) ?
                   BKT_W'(est_q - (BKT_W+1)'(NUM_BUCKETS)) : est_q[BKT_W-1:0];

  assign base      = ENT_W'(32'(rem_q) * 32'(WAYS));
  assign rd_way    = cmd_i.rd_valid ? '0 : way_q + 1'b1;
  assign rd_en     = cmd_i.rd_valid || (cmd_i.scan_eval && !status_o.scan_last);
  assign cur_valid = vrow_q[way_q];
  assign sel_way   = found_q ? hit_way_q : pick_q;
  assign idx_full  = 32'(base) + 32'(sel_way) + 32'd1;
  assign pick_mask = WAYS'(1) << sel_way;
  assign cnt_inc   = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;
  assign num_inc   = (next_num_q == '1) ? sclfu_pkg::NUM_W'(1) : next_num_q + 1'b1;

  always_comb begin
    wr_word.tag = tag_q;
    if (found_q) begin
      wr_word.cnt = cnt_inc;
      wr_word.num = hit_num_q;
    end else begin
      wr_word.cnt = sclfu_pkg::CNT_W'(1);
      wr_word.num = next_num_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      vmem[clr_q] <= '0;
    end else if (cmd_i.commit && !found_q) begin
      vmem[rem_q] <= vrow_q | pick_mask;
    end
    if (cmd_i.rd_valid) begin
      vrow_q <= vmem[rem_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      emem[base + ENT_W'(sel_way)] <= wr_word;
    end
    if (rd_en) begin
      rd_q <= emem[base + ENT_W'(rd_way)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      mod_cnt_q   <= '0;
      way_q       <= '0;
      next_num_q  <= sclfu_pkg::NUM_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.load_in) begin
        mod_cnt_q <= '0;
      end else if (cmd_i.mod_step) begin
        mod_cnt_q <= mod_cnt_q + 1'b1;
      end
      if (cmd_i.rd_valid) begin
        way_q <= '0;
      end else if (cmd_i.scan_eval && !status_o.scan_last) begin
        way_q <= way_q + 1'b1;
      end
      if (cmd_i.commit && !found_q) begin
        next_num_q <= num_inc;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      hash_q <= query_hash_i;
      tag_q  <= query_tag_i;
    end else if (cmd_i.mod_step) begin
      prod_q <= PROD_W'(hash_q) * PROD_W'(RCP_M);
      est_q  <= rem_raw[BKT_W:0];
      rem_q  <= rem_fix;
    end
  end

  // first matching way, and first free or first least-count way
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_valid) begin
      found_q <= 1'b0;
      free_q  <= 1'b0;
      pick_q  <= '0;
    end else if (cmd_i.scan_eval) begin
      if (cur_valid && (rd_q.tag == tag_q) && !found_q) begin
        found_q   <= 1'b1;
        hit_way_q <= way_q;
        hit_cnt_q <= rd_q.cnt;
        hit_num_q <= rd_q.num;
      end
      if (!free_q) begin
        if (!cur_valid) begin
          free_q <= 1'b1;
          pick_q <= way_q;
        end else if ((way_q == '0) || (rd_q.cnt < min_q)) begin
          min_q      <= rd_q.cnt;
          pick_q     <= way_q;
          pick_num_q <= rd_q.num;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q     <= found_q;
      idx_q     <= idx_full[sclfu_pkg::IDX_W-1:0];
      stmt_q    <= found_q ? hit_num_q : next_num_q;
      evicted_q <= !found_q && !free_q;
      ev_num_q  <= (!found_q && !free_q) ? pick_num_q : '0;
    end
  end

  assign status_o.clr_last  = (clr_q == BKT_W'(NUM_BUCKETS - 1));
  assign status_o.mod_last  = (mod_cnt_q == sclfu_pkg::MOD_CNT_W'(sclfu_pkg::MOD_CYCLES - 1));
  assign status_o.scan_last = (way_q == WAY_W'(WAYS - 1));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign entry_index_o    = idx_q;
  assign stmt_number_o    = stmt_q;
  assign evicted_o        = evicted_q;
  assign evicted_number_o = ev_num_q;

endmodule

>>> rtl/core/statement_cache_lfu_lookup.sv
// Channel  Dir  Handshake              Word
// in       in   in_valid_i/in_stall_o   query_hash_i, query_tag_i
// out      out  out_valid_o/out_stall_i hit_o, entry_index_o, stmt_number_o,
//                                       evicted_o, evicted_number_o
//
// A word passes from acceptance to commit through the bucket remainder unit, one
// valid-row read, one entry read per way and the commit, which waits for a free output.
// in_stall_o stays high until that commit, so the next word is taken only after it.
// After reset the valid-row memory is swept one bucket a cycle, every bucket in
// turn, with in_stall_o high throughout.
// The result sits in an output register; a stalled result holds the commit of
// the following word, not its acceptance or lookup.
`timescale 1ns / 1ps

module statement_cache_lfu_lookup #(
  parameter int unsigned NUM_BUCKETS = sclfu_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned WAYS        = sclfu_pkg::WAYS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sclfu_pkg::HASH_W-1:0] query_hash_i,
  input  logic [sclfu_pkg::TAG_W-1:0]  query_tag_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [sclfu_pkg::IDX_W-1:0]  entry_index_o,
  output logic [sclfu_pkg::NUM_W-1:0]  stmt_number_o,
  output logic                         evicted_o,
  output logic [sclfu_pkg::NUM_W-1:0]  evicted_number_o
);

  sclfu_pkg::cmd_t    cmd;
  sclfu_pkg::status_t status;

  sclfu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sclfu_datapath #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .query_hash_i     (query_hash_i),
    .query_tag_i      (query_tag_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .entry_index_o    (entry_index_o),
    .stmt_number_o    (stmt_number_o),
    .evicted_o        (evicted_o),
    .evicted_number_o (evicted_number_o)
  );

endmodule

>>> rtl/core/sclfu_checker.sv
`timescale 1ns / 1ps

module sclfu_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         hit_o,
  input logic [sclfu_pkg::IDX_W-1:0]  entry_index_o,
  input logic [sclfu_pkg::NUM_W-1:0]  stmt_number_o,
  input logic                         evicted_o,
  input logic [sclfu_pkg::NUM_W-1:0]  evicted_number_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled output word dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(stmt_number_o) && $stable(entry_index_o))
    else $error("stalled output word changed");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_o)
    else $error("hit reported with eviction");

  a_evict_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_o |-> (evicted_number_o == '0))
    else $error("evicted number without eviction");

  a_stmt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (stmt_number_o != '0))
    else $error("statement number zero");

endmodule

bind statement_cache_lfu_lookup sclfu_checker u_sclfu_checker (.*);

>>> tb/tb_statement_cache_lfu_lookup.sv
`timescale 1ns / 1ps

module tb_statement_cache_lfu_lookup;

  localparam int unsigned NB        = sclfu_pkg::NUM_BUCKETS_DEF;
  localparam int unsigned NW        = sclfu_pkg::WAYS_DEF;
  localparam int unsigned SLOTS     = NB * NW;
  localparam int unsigned HOT_SETS  = 16;
  localparam int unsigned HOT_TAGS  = 12;
  localparam int unsigned QUIET_MAX = 6000;

  typedef struct packed {
    logic                        hit;
    logic [sclfu_pkg::IDX_W-1:0] entry_index;
    logic [sclfu_pkg::NUM_W-1:0] stmt_number;
    logic                        evicted;
    logic [sclfu_pkg::NUM_W-1:0] evicted_number;
  } lookup_word_t;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_stall_o;
  logic [sclfu_pkg::HASH_W-1:0] query_hash_i = '0;
  logic [sclfu_pkg::TAG_W-1:0]  query_tag_i  = '0;
  logic                         out_valid_o;
  logic                         out_stall_i  = 1'b0;
  logic                         hit_o;
  logic [sclfu_pkg::IDX_W-1:0]  entry_index_o;
  logic [sclfu_pkg::NUM_W-1:0]  stmt_number_o;
  logic                         evicted_o;
  logic [sclfu_pkg::NUM_W-1:0]  evicted_number_o;

  bit                          cache_valid [SLOTS];
  logic [sclfu_pkg::TAG_W-1:0] cache_tag   [SLOTS];
  logic [sclfu_pkg::CNT_W-1:0] cache_runs  [SLOTS];
  logic [sclfu_pkg::NUM_W-1:0] cache_stmt  [SLOTS];
  logic [sclfu_pkg::NUM_W-1:0] next_stmt = 1;

  lookup_word_t                pending_lookups [$];
  int unsigned                 hot_buckets [HOT_SETS];
  logic [sclfu_pkg::TAG_W-1:0] hot_tags    [HOT_SETS][HOT_TAGS];
  int                          mismatches  = 0;
  int                          quiet_cycles = 0;
  int                          out_burst   = 0;
  bit                          steady      = 1'b0;

  statement_cache_lfu_lookup #(
    .NUM_BUCKETS(NB),
    .WAYS       (NW)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .query_hash_i    (query_hash_i),
    .query_tag_i     (query_tag_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .entry_index_o   (entry_index_o),
    .stmt_number_o   (stmt_number_o),
    .evicted_o       (evicted_o),
    .evicted_number_o(evicted_number_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic lookup_word_t predict_lookup(
      input logic [sclfu_pkg::HASH_W-1:0] hash,
      input logic [sclfu_pkg::TAG_W-1:0]  tag);
    int unsigned  base;
    int unsigned  slot;
    bit           found;
    bit           free_way;
    lookup_word_t res;
    base     = (hash % NB) * NW;
    slot     = base;
    found    = 1'b0;
    free_way = 1'b0;
    res      = '0;
    for (int unsigned w = 0; w < NW; w++) begin
      if (!found && cache_valid[base+w] && cache_tag[base+w] == tag) begin
        found = 1'b1;
        slot  = base + w;
      end
    end
    if (found) begin
      if (cache_runs[slot] != '1) cache_runs[slot] = cache_runs[slot] + 1;
    end else begin
      for (int unsigned w = 0; w < NW; w++) begin
        if (!free_way) begin
          if (!cache_valid[base+w]) begin
            slot     = base + w;
            free_way = 1'b1;
          end else if (cache_runs[base+w] < cache_runs[slot]) begin
            slot = base + w;
          end
        end
      end
      if (!free_way) begin
        res.evicted        = 1'b1;
        res.evicted_number = cache_stmt[slot];
      end
      cache_valid[slot] = 1'b1;
      cache_tag[slot]   = tag;
      cache_runs[slot]  = 1;
      cache_stmt[slot]  = next_stmt;
      next_stmt         = (next_stmt == '1) ? sclfu_pkg::NUM_W'(1) : next_stmt + 1;
    end
    res.hit         = found;
    res.entry_index = sclfu_pkg::IDX_W'(slot + 1);
    res.stmt_number = cache_stmt[slot];
    return res;
  endfunction

  function automatic logic [sclfu_pkg::HASH_W-1:0] hash_in_bucket(input int unsigned bucket);
    int unsigned k;
    k = $urandom_range(0, (32'hFFFF_FFFF - bucket) / NB);
    return sclfu_pkg::HASH_W'(bucket + k * NB);
  endfunction

  task automatic send_query(input logic [sclfu_pkg::HASH_W-1:0] hash,
                            input logic [sclfu_pkg::TAG_W-1:0]  tag);
    in_valid_i   <= 1'b1;
    query_hash_i <= hash;
    query_tag_i  <= tag;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_lookups.push_back(predict_lookup(hash, tag));
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (pending_lookups.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_field_extremes();
    send_query(32'h0000_0000, 64'h0);
    send_query(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_query(sclfu_pkg::HASH_W'(NB - 1), 64'hAAAA_AAAA_AAAA_AAAA);
    send_query(sclfu_pkg::HASH_W'(NB), 64'h5555_5555_5555_5555);
    send_query(32'h0000_0000, 64'h0);
    send_query(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_lfu_replacement();
    logic [sclfu_pkg::TAG_W-1:0] fill_tags [NW];
    logic [sclfu_pkg::TAG_W-1:0] fresh_tag;
    for (int i = 0; i < NW; i++) fill_tags[i] = {$urandom, $urandom};
    fresh_tag = {$urandom, $urandom};
    // fill every way, then lift ways 0 and 2 above the rest
    for (int i = 0; i < NW; i++) send_query(hash_in_bucket(7), fill_tags[i]);
    send_query(hash_in_bucket(7), fill_tags[0]);
    send_query(hash_in_bucket(7), fill_tags[2]);
    // tie on the least count: lowest way goes first
    send_query(hash_in_bucket(7), fresh_tag);
    send_query(hash_in_bucket(7), fill_tags[1]);
    send_query(hash_in_bucket(7), fresh_tag);
    send_query(hash_in_bucket(7), fill_tags[0]);
  endtask

  task automatic send_hot_query();
    int unsigned set_sel;
    int unsigned pick;
    set_sel = $urandom_range(0, HOT_SETS - 1);
    pick    = $urandom_range(0, 9);
    if (pick < 8)
      send_query(hash_in_bucket(hot_buckets[set_sel]),
                 hot_tags[set_sel][$urandom_range(0, $urandom_range(0, HOT_TAGS - 1))]);
    else if (pick == 8)
      send_query($urandom, {$urandom, $urandom});
    else
      send_query(hash_in_bucket(hot_buckets[set_sel]), {$urandom, $urandom});
  endtask

  task automatic test_hot_bucket_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      send_hot_query();
      if (i == count / 2) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
    end
  endtask

  task automatic test_streaming(input int count);
    for (int i = 0; i < count; i++) send_hot_query();
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    lookup_word_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual idx %0h stmt %0h",
                 $time, entry_index_o, stmt_number_o);
        mismatches++;
      end else begin
        want = pending_lookups.pop_front();
        report_field("hit", want.hit, hit_o);
        report_field("entry_index", want.entry_index, entry_index_o);
        report_field("stmt_number", want.stmt_number, stmt_number_o);
        report_field("evicted", want.evicted, evicted_o);
        report_field("evicted_number", want.evicted_number, evicted_number_o);
      end
    end
    if (steady) begin
      out_stall_i <= 1'b0;
    end else if (out_burst == 0) begin
      out_burst = $urandom_range(1, 11);
      out_stall_i <= ($urandom_range(0, 2) == 0);
    end else begin
      out_burst--;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    hot_buckets[0] = 0;
    hot_buckets[1] = NB - 1;
    for (int s = 2; s < HOT_SETS; s++) hot_buckets[s] = $urandom_range(1, NB - 2);
    for (int s = 0; s < HOT_SETS; s++)
      for (int t = 0; t < HOT_TAGS; t++) hot_tags[s][t] = {$urandom, $urandom};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_field_extremes();
    test_lfu_replacement();
    test_hot_bucket_traffic(1000);
    steady = 1'b1;
    test_streaming(280);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
